>>> hdl/plc_pkg.sv
// Package for the POP3 line classifier: keyword table, command codes and
// the classified-line word type passed from the front end to the back end.
// No dependencies.
package plc_pkg;

    localparam int unsigned QueueDepthDefault = 2;
    localparam int unsigned NumKeywords       = 13;

    localparam logic [3:0] CMD_UNKNOWN = 4'd0;
    localparam logic [3:0] CMD_USER    = 4'd1;
    localparam logic [3:0] CMD_PASS    = 4'd2;
    localparam logic [3:0] CMD_STAT    = 4'd3;
    localparam logic [3:0] CMD_LIST    = 4'd4;
    localparam logic [3:0] CMD_RETR    = 4'd5;
    localparam logic [3:0] CMD_DELE    = 4'd6;
    localparam logic [3:0] CMD_NOOP    = 4'd7;
    localparam logic [3:0] CMD_RSET    = 4'd8;
    localparam logic [3:0] CMD_QUIT    = 4'd9;
    localparam logic [3:0] CMD_TOP     = 4'd10;
    localparam logic [3:0] CMD_UIDL    = 4'd11;
    localparam logic [3:0] CMD_APOP    = 4'd12;
    localparam logic [3:0] CMD_CAPA    = 4'd13;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // keyword text, entry k holds command code k+1
    localparam logic [31:0] KW_TEXT [NumKeywords] = '{
        "USER", "PASS", "STAT", "LIST", "RETR", "DELE", "NOOP",
        "RSET", "QUIT", {"TOP", 8'h00}, "UIDL", "APOP", "CAPA"
    };
    localparam logic [2:0] KW_LEN [NumKeywords] = '{
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    typedef struct packed {
        logic       is_response;
        logic       response_ok;
        logic [3:0] command_code;
        logic [3:0] arg_count;
        logic       syntax_valid;
    } t_line_word;

endpackage

>>> hdl/plc_front.sv
// Front end: takes stream bytes, tracks line state and classifies each
// non-blank line at its LF into a t_line_word. Depends on plc_pkg.
module plc_front import plc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_line_word o_word
);

    logic       r_nonblank, n_nonblank;
    logic [7:0] r_pfx [4];
    logic [7:0] n_pfx [4];
    logic [2:0] r_pfx_len, n_pfx_len;
    logic [7:0] r_tok [4];
    logic [7:0] n_tok [4];
    logic [2:0] r_tok_len, n_tok_len;
    logic       r_in_tok, n_in_tok;
    logic [4:0] r_tok_cnt, n_tok_cnt;

    logic       is_lf, ws_pfx, ws_tok;
    logic [7:0] upper_b;

    function automatic logic [3:0] keyword_code(input logic [7:0] tok [4],
                                                input logic [2:0] len);
        logic [3:0] code;
        logic       same;
        code = CMD_UNKNOWN;
        for (int k = NumKeywords - 1; k >= 0; k--) begin
            same = (len == KW_LEN[k]);
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < KW_LEN[k] && tok[i] != KW_TEXT[k][31-8*i -: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                code = 4'(k + 1);
            end
        end
        return code;
    endfunction

    function automatic logic args_legal(input logic [3:0] code,
                                        input logic [3:0] args);
        logic ok;
        case (code)
            CMD_USER, CMD_PASS:                       ok = (args == 4'd1);
            CMD_LIST, CMD_RETR, CMD_DELE, CMD_UIDL:   ok = (args <= 4'd1);
            CMD_TOP, CMD_APOP:                        ok = (args == 4'd2);
            CMD_STAT, CMD_NOOP, CMD_RSET, CMD_QUIT,
            CMD_CAPA:                                 ok = (args == 4'd0);
            default:                                  ok = 1'b0;
        endcase
        return ok;
    endfunction

    logic       resp_ok, resp_err;
    logic [3:0] code, args;

    assign is_lf   = (i_byte == CH_LF);
    assign ws_pfx  = (i_byte == CH_SPACE) || (i_byte == CH_TAB) || (i_byte == CH_CR);
    assign ws_tok  = (i_byte == CH_SPACE) || (i_byte >= CH_TAB && i_byte <= CH_CR);
    assign upper_b = (i_byte >= "a" && i_byte <= "z") ? i_byte - 8'd32 : i_byte;

    // classification of the stored line
    assign resp_ok  = (r_pfx_len >= 3'd3) && r_pfx[0] == "+" && r_pfx[1] == "O"
                      && r_pfx[2] == "K";
    assign resp_err = (r_pfx_len >= 3'd4) && r_pfx[0] == "-" && r_pfx[1] == "E"
                      && r_pfx[2] == "R" && r_pfx[3] == "R";
    assign code     = keyword_code(r_tok, r_tok_len);
    assign args     = (r_tok_cnt == 5'd0) ? 4'd0 :
                      (r_tok_cnt[4]       ? 4'd15 : 4'(r_tok_cnt - 5'd1));

    always_comb begin
        o_word.is_response  = resp_ok || resp_err;
        o_word.response_ok  = resp_ok;
        o_word.command_code = (resp_ok || resp_err) ? CMD_UNKNOWN : code;
        o_word.arg_count    = (resp_ok || resp_err) ? 4'd0 : args;
        o_word.syntax_valid = (resp_ok || resp_err) ? 1'b1 : args_legal(code, args);
    end

    assign o_push = i_accept && is_lf && r_nonblank;

    always_comb begin
        n_nonblank = r_nonblank;
        n_pfx      = r_pfx;
        n_pfx_len  = r_pfx_len;
        n_tok      = r_tok;
        n_tok_len  = r_tok_len;
        n_in_tok   = r_in_tok;
        n_tok_cnt  = r_tok_cnt;
        if (i_accept) begin
            if (is_lf) begin
                n_nonblank = 1'b0;
                n_pfx_len  = 3'd0;
                n_tok_len  = 3'd0;
                n_in_tok   = 1'b0;
                n_tok_cnt  = 5'd0;
            end else begin
                n_nonblank = r_nonblank || !ws_pfx;
                if (n_nonblank && r_pfx_len < 3'd4) begin
                    n_pfx[r_pfx_len[1:0]] = i_byte;
                    n_pfx_len             = r_pfx_len + 3'd1;
                end
                if (ws_tok) begin
                    n_in_tok = 1'b0;
                end else begin
                    n_in_tok = 1'b1;
                    if (!r_in_tok && r_tok_cnt < 5'd16) begin
                        n_tok_cnt = r_tok_cnt + 5'd1;
                    end
                    if (n_tok_cnt == 5'd1) begin
                        if (r_tok_len < 3'd4) begin
                            n_tok[r_tok_len[1:0]] = upper_b;
                        end
                        if (r_tok_len < 3'd5) begin
                            n_tok_len = r_tok_len + 3'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfx <= n_pfx;
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_nonblank <= 1'b0;
            r_pfx_len  <= 3'd0;
            r_tok_len  <= 3'd0;
            r_in_tok   <= 1'b0;
            r_tok_cnt  <= 5'd0;
        end else begin
            r_nonblank <= n_nonblank;
            r_pfx_len  <= n_pfx_len;
            r_tok_len  <= n_tok_len;
            r_in_tok   <= n_in_tok;
            r_tok_cnt  <= n_tok_cnt;
        end
    end

endmodule

>>> hdl/plc_queue.sv
// Short register FIFO of classified-line words between front and back end.
// Depends on plc_pkg.
module plc_queue import plc_pkg::*; #(
    parameter int unsigned Depth = QueueDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_line_word i_word,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_nonempty,
    output t_line_word o_word
);

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_line_word            r_mem [Depth];
    logic [PtrW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]       r_cnt;

    function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    assign o_full     = (r_cnt == CntW'(Depth));
    assign o_nonempty = (r_cnt != '0);
    assign o_word     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CntW'(1);
                2'b01:   r_cnt <= r_cnt - CntW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hdl/plc_back.sv
// Back end: pops classified words, updates the command and response
// totals and holds the result word in the output register. Depends on plc_pkg.
module plc_back import plc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nonempty,
    input  t_line_word  i_word,
    output logic        o_pop,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_line_word  o_word,
    output logic [15:0] o_command_total,
    output logic [15:0] o_response_total
);

    logic        r_valid;
    t_line_word  r_word;
    logic [15:0] r_cmd_cnt, n_cmd_cnt;
    logic [15:0] r_resp_cnt, n_resp_cnt;

    assign o_pop = i_nonempty && (!r_valid || i_out_ready);

    assign n_cmd_cnt  = r_cmd_cnt + 16'(!i_word.is_response && i_word.syntax_valid);
    assign n_resp_cnt = r_resp_cnt + 16'(i_word.is_response);

    assign o_out_valid      = r_valid;
    assign o_word           = r_word;
    assign o_command_total  = r_cmd_cnt;
    assign o_response_total = r_resp_cnt;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_word;
        end
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_cmd_cnt  <= 16'd0;
            r_resp_cnt <= 16'd0;
        end else begin
            if (o_pop) begin
                r_valid    <= 1'b1;
                r_cmd_cnt  <= n_cmd_cnt;
                r_resp_cnt <= n_resp_cnt;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/pop3_line_classifier_core.sv
// Channel  | Direction | Handshake                 | Word
// byte in  | in        | i_in_valid / o_in_ready   | i_byte_in
// result   | out       | o_out_valid / i_out_ready | o_is_response .. o_response_total
//
// One byte per cycle while o_in_ready is high. A line is classified as its LF
// is accepted and its word written to the queue at that edge. Words move in order
// to the output register, setting o_out_valid, unless it holds an untaken word.
// Reset is synchronous, active low, and leaves no line pending.
// A stalled output fills the queue (QueueDepth words); the input stalls only
// once the queue is full, and then every byte waits, LF or not.
module pop3_line_classifier_core import plc_pkg::*; #(
    parameter int unsigned QueueDepth = QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_response,
    output logic        o_response_ok,
    output logic [3:0]  o_command_code,
    output logic [3:0]  o_arg_count,
    output logic        o_syntax_valid,
    output logic [15:0] o_command_total,
    output logic [15:0] o_response_total
);

    logic       accept, push, pop, q_full, q_nonempty;
    t_line_word front_word, q_word, out_word;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && !q_full;

    plc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_byte_in),
        .o_push   (push),
        .o_word   (front_word)
    );

    plc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_word     (front_word),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_word     (q_word)
    );

    plc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_nonempty       (q_nonempty),
        .i_word           (q_word),
        .o_pop            (pop),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_word           (out_word),
        .o_command_total  (o_command_total),
        .o_response_total (o_response_total)
    );

    assign o_is_response  = out_word.is_response;
    assign o_response_ok  = out_word.response_ok;
    assign o_command_code = out_word.command_code;
    assign o_arg_count    = out_word.arg_count;
    assign o_syntax_valid = out_word.syntax_valid;

endmodule
